>>> hw/rtl/qmr_pkg.sv
package qmr_pkg;

   // Default number of fraction bits in a quaternion component.
   localparam int FRAC_BITS_DEF = 14;

   // Operation codes.
   localparam logic OP_PRODUCT = 1'b0;
   localparam logic OP_ROTATE  = 1'b1;

   // Component positions in the four-element operand arrays.
   localparam int NCOMP = 4;
   localparam int IX    = 0;
   localparam int IY    = 1;
   localparam int IZ    = 2;
   localparam int IW    = 3;

   // Datapath widths: component, first product rank, first sums,
   // second product rank and final sums.
   localparam int COMP_W = 16;
   localparam int PROD_W = 2 * COMP_W;
   localparam int QT_W   = PROD_W + 2;
   localparam int ROT_W  = QT_W + COMP_W;
   localparam int ACC_W  = ROT_W + 2;

   // Saturation bounds of a result component.
   localparam logic signed [COMP_W-1:0] COMP_MAX = 16'sh7FFF;
   localparam logic signed [COMP_W-1:0] COMP_MIN = 16'sh8000;

   typedef struct packed {
      logic                     operation;
      logic signed [COMP_W-1:0] a_x;
      logic signed [COMP_W-1:0] a_y;
      logic signed [COMP_W-1:0] a_z;
      logic signed [COMP_W-1:0] a_w;
      logic signed [COMP_W-1:0] b_x;
      logic signed [COMP_W-1:0] b_y;
      logic signed [COMP_W-1:0] b_z;
      logic signed [COMP_W-1:0] b_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] r_x;
      logic signed [COMP_W-1:0] r_y;
      logic signed [COMP_W-1:0] r_z;
      logic signed [COMP_W-1:0] r_w;
   } rsp_payload_type;

endpackage

>>> hw/rtl/qmr_req_if.sv
interface qmr_req_if;
   logic                     valid;
   logic                     ready;
   qmr_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/qmr_rsp_if.sv
interface qmr_rsp_if;
   logic                     valid;
   logic                     ready;
   qmr_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/qmr_prod_stage.sv
module qmr_prod_stage #(
   parameter int AW = qmr_pkg::COMP_W,
   parameter int BW = qmr_pkg::COMP_W
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    op_a    [qmr_pkg::NCOMP],
   input  logic signed [BW-1:0]    op_b    [qmr_pkg::NCOMP],
   output logic signed [AW+BW-1:0] prod_ff [qmr_pkg::NCOMP][qmr_pkg::NCOMP]
);
   import qmr_pkg::*;

   logic signed [AW+BW-1:0] prod_in [NCOMP][NCOMP];

   // Every cross product of the two operands, one multiplier each.
   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         for (int j = 0; j < NCOMP; j++) begin
            prod_in[i][j] = op_a[i] * op_b[j];
         end
      end
   end

   // Product rank register; it holds while the stage is stalled.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

>>> hw/rtl/quaternion_multiply_and_rotate.sv
// Channel  Port    Direction  Payload
// request  req_ch  in         operation, a_x..a_w, b_x..b_w (signed 16)
// response rsp_ch  out        r_x, r_y, r_z, r_w (signed 16)
//
// Five register stages: products of a and b, their Hamilton sums, products
// with a again, the rotation sums, then rounding and saturation into the
// output register. One transaction can enter every cycle unless rsp_ch
// stalls; each passes through the stages in that order. Reset clears the
// stage valid bits only. A full stage holds while the stage after it is blocked,
// so a stall on rsp_ch fills empty stages first and only then drops req_ch.ready.
module quaternion_multiply_and_rotate #(
   parameter int FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   qmr_req_if.sink   req_ch,
   qmr_rsp_if.source rsp_ch
);
   import qmr_pkg::*;

   localparam int NSTAGE = 5;

   // Rounding offsets for the two result scales.
   localparam logic signed [ACC_W-1:0] HALF_PROD =
      {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] HALF_ROT =
      {{(ACC_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);

   logic [NSTAGE:1] valid_ff;
   logic [NSTAGE:1] valid_in;
   logic [NSTAGE:1] en;

   logic signed [COMP_W-1:0] a_in  [NCOMP];
   logic signed [COMP_W-1:0] b_in  [NCOMP];
   logic signed [COMP_W-1:0] a1_ff [NCOMP];
   logic                     op1_ff;
   logic signed [PROD_W-1:0] p1_ff [NCOMP][NCOMP];

   logic signed [QT_W-1:0]   t2_in [NCOMP];
   logic signed [QT_W-1:0]   t2_ff [NCOMP];
   logic signed [COMP_W-1:0] a2_ff [NCOMP];
   logic                     op2_ff;

   logic signed [ROT_W-1:0]  q3_ff [NCOMP][NCOMP];
   logic signed [QT_W-1:0]   t3_ff [NCOMP];
   logic                     op3_ff;

   logic signed [ACC_W-1:0]  val4_in [NCOMP];
   logic signed [ACC_W-1:0]  val4_ff [NCOMP];
   logic                     op4_ff;

   logic signed [ACC_W-1:0]  biased  [NCOMP];
   logic signed [ACC_W-1:0]  shifted [NCOMP];
   logic signed [COMP_W-1:0] sat     [NCOMP];
   rsp_payload_type          out_in;
   rsp_payload_type          out_ff;

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      en[NSTAGE] = !valid_ff[NSTAGE] || rsp_ch.ready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = req_ch.valid;
      for (int k = 2; k <= NSTAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_ch.ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTAGE; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage 1: operands in component order; the vector's scalar is zero when rotating.
   always_comb begin
      a_in[IX] = req_ch.data.a_x;
      a_in[IY] = req_ch.data.a_y;
      a_in[IZ] = req_ch.data.a_z;
      a_in[IW] = req_ch.data.a_w;
      b_in[IX] = req_ch.data.b_x;
      b_in[IY] = req_ch.data.b_y;
      b_in[IZ] = req_ch.data.b_z;
      b_in[IW] = (req_ch.data.operation == OP_ROTATE) ? '0 : req_ch.data.b_w;
   end

   qmr_prod_stage #(
      .AW (COMP_W),
      .BW (COMP_W)
   ) u_prod_ab (
      .clock   (clock),
      .en      (en[1]),
      .op_a    (a_in),
      .op_b    (b_in),
      .prod_ff (p1_ff)
   );

   always_ff @(posedge clock) begin
      if (en[1]) begin
         a1_ff  <= a_in;
         op1_ff <= req_ch.data.operation;
      end
   end

   // Stage 2: Hamilton sums of a*b at full width.
   always_comb begin
      t2_in[IX] = QT_W'(p1_ff[IW][IX]) + QT_W'(p1_ff[IX][IW])
                + QT_W'(p1_ff[IY][IZ]) - QT_W'(p1_ff[IZ][IY]);
      t2_in[IY] = QT_W'(p1_ff[IW][IY]) + QT_W'(p1_ff[IY][IW])
                + QT_W'(p1_ff[IZ][IX]) - QT_W'(p1_ff[IX][IZ]);
      t2_in[IZ] = QT_W'(p1_ff[IW][IZ]) + QT_W'(p1_ff[IZ][IW])
                + QT_W'(p1_ff[IX][IY]) - QT_W'(p1_ff[IY][IX]);
      t2_in[IW] = QT_W'(p1_ff[IW][IW]) - QT_W'(p1_ff[IX][IX])
                - QT_W'(p1_ff[IY][IY]) - QT_W'(p1_ff[IZ][IZ]);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         t2_ff  <= t2_in;
         a2_ff  <= a1_ff;
         op2_ff <= op1_ff;
      end
   end

   // Stage 3: products of a*b with each component of a; conj(a) is folded
   // into the signs of the next sums.
   qmr_prod_stage #(
      .AW (QT_W),
      .BW (COMP_W)
   ) u_prod_ta (
      .clock   (clock),
      .en      (en[3]),
      .op_a    (t2_ff),
      .op_b    (a2_ff),
      .prod_ff (q3_ff)
   );

   always_ff @(posedge clock) begin
      if (en[3]) begin
         t3_ff  <= t2_ff;
         op3_ff <= op2_ff;
      end
   end

   // Stage 4: vector part of (a*v)*conj(a), or the plain product passed on.
   always_comb begin
      if (op3_ff == OP_ROTATE) begin
         val4_in[IX] = ACC_W'(q3_ff[IX][IW]) - ACC_W'(q3_ff[IW][IX])
                     + ACC_W'(q3_ff[IZ][IY]) - ACC_W'(q3_ff[IY][IZ]);
         val4_in[IY] = ACC_W'(q3_ff[IY][IW]) - ACC_W'(q3_ff[IW][IY])
                     + ACC_W'(q3_ff[IX][IZ]) - ACC_W'(q3_ff[IZ][IX]);
         val4_in[IZ] = ACC_W'(q3_ff[IZ][IW]) - ACC_W'(q3_ff[IW][IZ])
                     + ACC_W'(q3_ff[IY][IX]) - ACC_W'(q3_ff[IX][IY]);
         val4_in[IW] = '0;
      end else begin
         for (int i = 0; i < NCOMP; i++) begin
            val4_in[i] = ACC_W'(t3_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         val4_ff <= val4_in;
         op4_ff  <= op3_ff;
      end
   end

   // Stage 5: round half up, drop the fraction bits and saturate to 16 bits.
   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         if (op4_ff == OP_ROTATE) begin
            biased[i]  = val4_ff[i] + HALF_ROT;
            shifted[i] = biased[i] >>> (2 * FRAC_BITS);
         end else begin
            biased[i]  = val4_ff[i] + HALF_PROD;
            shifted[i] = biased[i] >>> FRAC_BITS;
         end
         if (shifted[i] > ACC_W'(COMP_MAX)) begin
            sat[i] = COMP_MAX;
         end else if (shifted[i] < ACC_W'(COMP_MIN)) begin
            sat[i] = COMP_MIN;
         end else begin
            sat[i] = shifted[i][COMP_W-1:0];
         end
      end
      out_in.r_x = sat[IX];
      out_in.r_y = sat[IY];
      out_in.r_z = sat[IZ];
      out_in.r_w = sat[IW];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = valid_ff[NSTAGE];
   assign rsp_ch.data  = out_ff;

`ifndef SYNTHESIS
   // Requests are refused only when every stage holds a transaction.
   a_ready_only_when_full : assert property (
      @(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff)
   ) else $error("request refused while the pipeline has an empty stage");

   // A blocked stage 4 keeps its transaction and the x component of its value.
   a_stage4_holds : assert property (
      @(posedge clock) disable iff (reset)
      valid_ff[4] && !en[5] |=> valid_ff[4] && $stable(val4_ff[IX])
   ) else $error("stage 4 lost or changed a stalled transaction");

   // A rotation that moves into the output register shows a zero scalar.
   a_rotate_w_zero : assert property (
      @(posedge clock) disable iff (reset)
      valid_ff[4] && op4_ff == OP_ROTATE && en[5] |=> rsp_ch.data.r_w == '0
   ) else $error("rotation result has a nonzero scalar part");
`endif

endmodule

>>> tb/qmr_response_checker.sv
`timescale 1ns / 1ps

module qmr_response_checker #(
   parameter int FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   qmr_req_if   req_ch,
   qmr_rsp_if   rsp_ch,
   output int   error_count,
   output int   pending_count
);
   import qmr_pkg::*;

   // Quaternion with components wide enough for every full-width intermediate.
   typedef struct {
      longint x;
      longint y;
      longint z;
      longint w;
   } wide_quat_type;

   rsp_payload_type expected_responses[$];
   rsp_payload_type oldest_response;

   // Full-width Hamilton product p*q.
   function automatic wide_quat_type hamilton_product(wide_quat_type p, wide_quat_type q);
      wide_quat_type r;
      r.x = p.w * q.x + q.w * p.x + p.y * q.z - p.z * q.y;
      r.y = p.w * q.y + q.w * p.y + p.z * q.x - p.x * q.z;
      r.z = p.w * q.z + q.w * p.z + p.x * q.y - p.y * q.x;
      r.w = p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z;
      return r;
   endfunction

   // Round to nearest with ties toward plus infinity, then clamp to 16 bits.
   function automatic logic signed [COMP_W-1:0] round_saturate(longint value, int shift);
      longint rounded;
      rounded = (value + (longint'(1) <<< (shift - 1))) >>> shift;
      if (rounded > longint'(COMP_MAX)) rounded = longint'(COMP_MAX);
      if (rounded < longint'(COMP_MIN)) rounded = longint'(COMP_MIN);
      return rounded[COMP_W-1:0];
   endfunction

   // Product a*b, or rotation a*v*conj(a) with b_w taken as zero.
   function automatic rsp_payload_type predict_response(req_payload_type item);
      wide_quat_type   a;
      wide_quat_type   b;
      wide_quat_type   a_conj;
      wide_quat_type   r;
      rsp_payload_type rsp;
      int              shift;
      a.x = longint'(item.a_x);
      a.y = longint'(item.a_y);
      a.z = longint'(item.a_z);
      a.w = longint'(item.a_w);
      b.x = longint'(item.b_x);
      b.y = longint'(item.b_y);
      b.z = longint'(item.b_z);
      b.w = longint'(item.b_w);
      if (item.operation == OP_PRODUCT) begin
         r     = hamilton_product(a, b);
         shift = FRAC_BITS;
         rsp.r_w = round_saturate(r.w, shift);
      end else begin
         b.w      = 0;
         a_conj.x = -a.x;
         a_conj.y = -a.y;
         a_conj.z = -a.z;
         a_conj.w = a.w;
         r        = hamilton_product(hamilton_product(a, b), a_conj);
         shift    = 2 * FRAC_BITS;
         rsp.r_w  = '0;
      end
      rsp.r_x = round_saturate(r.x, shift);
      rsp.r_y = round_saturate(r.y, shift);
      rsp.r_z = round_saturate(r.z, shift);
      return rsp;
   endfunction

   task automatic report_mismatch(string message);
      $display("%0t ns: response mismatch: %s", $time, message);
      error_count++;
   endtask

   task automatic check_component(string name, logic signed [COMP_W-1:0] got,
                                  logic signed [COMP_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // Predict on every accepted request and compare every accepted response
   // against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         expected_responses.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_responses.push_back(predict_response(req_ch.data));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               oldest_response = expected_responses.pop_front();
               check_component("r_x", rsp_ch.data.r_x, oldest_response.r_x);
               check_component("r_y", rsp_ch.data.r_y, oldest_response.r_y);
               check_component("r_z", rsp_ch.data.r_z, oldest_response.r_z);
               check_component("r_w", rsp_ch.data.r_w, oldest_response.r_w);
            end
         end
      end
      pending_count = expected_responses.size();
   end

endmodule

>>> tb/tb_quaternion_multiply_and_rotate.sv
`timescale 1ns / 1ps

module tb_quaternion_multiply_and_rotate;
   import qmr_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int IDLE_PERCENT    = 33;
   localparam int HOLD_CYCLES     = 80;
   localparam int DRAIN_CYCLES    = 12;
   localparam int ONE             = 1 << FRAC_BITS_DEF;
   localparam int COS_45          = 11585;
   localparam int RANDOM_PHASE_1  = 800;
   localparam int STEADY_PHASE    = 400;
   localparam int RANDOM_PHASE_2  = 800;
   localparam int REQ_W           = $bits(req_payload_type);

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   bit   idle_enable;
   bit   hold_request;
   int   hold_cycles_left;

   qmr_req_if req_ch ();
   qmr_rsp_if rsp_ch ();

   quaternion_multiply_and_rotate dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   qmr_response_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog for a hung handshake.
   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic req_payload_type make_request(logic op, int ax, int ay, int az, int aw,
                                                    int bx, int by, int bz, int bw);
      req_payload_type item;
      item.operation = op;
      item.a_x = ax[COMP_W-1:0];
      item.a_y = ay[COMP_W-1:0];
      item.a_z = az[COMP_W-1:0];
      item.a_w = aw[COMP_W-1:0];
      item.b_x = bx[COMP_W-1:0];
      item.b_y = by[COMP_W-1:0];
      item.b_z = bz[COMP_W-1:0];
      item.b_w = bw[COMP_W-1:0];
      return item;
   endfunction

   // Random unit quaternion scaled to the component format.
   task automatic make_unit_quaternion(output logic signed [COMP_W-1:0] x, y, z, w);
      real c[4];
      real norm;
      norm = 0.0;
      foreach (c[i]) begin
         c[i] = ($itor($urandom_range(20000)) - 10000.0) / 10000.0;
         norm += c[i] * c[i];
      end
      if (norm < 1.0e-6) begin
         c = '{0.0, 0.0, 0.0, 1.0};
         norm = 1.0;
      end
      norm = $sqrt(norm);
      x = COMP_W'($rtoi(c[0] / norm * ONE));
      y = COMP_W'($rtoi(c[1] / norm * ONE));
      z = COMP_W'($rtoi(c[2] / norm * ONE));
      w = COMP_W'($rtoi(c[3] / norm * ONE));
   endtask

   // Half unit quaternions (with full-range vectors for rotations), the rest
   // small values and unconstrained full-range words.
   task automatic make_random_request(output req_payload_type item);
      int flavor;
      flavor = $urandom_range(9);
      item.operation = $urandom_range(1) ? OP_ROTATE : OP_PRODUCT;
      item.b_x = COMP_W'($urandom());
      item.b_y = COMP_W'($urandom());
      item.b_z = COMP_W'($urandom());
      item.b_w = COMP_W'($urandom());
      if (flavor < 5) begin
         make_unit_quaternion(item.a_x, item.a_y, item.a_z, item.a_w);
         if (item.operation == OP_PRODUCT) begin
            make_unit_quaternion(item.b_x, item.b_y, item.b_z, item.b_w);
         end
      end else if (flavor < 7) begin
         item.a_x = COMP_W'($signed($urandom_range(512)) - 256);
         item.a_y = COMP_W'($signed($urandom_range(512)) - 256);
         item.a_z = COMP_W'($signed($urandom_range(512)) - 256);
         item.a_w = COMP_W'($signed($urandom_range(512)) - 256);
         item.b_x = COMP_W'($signed($urandom_range(512)) - 256);
         item.b_y = COMP_W'($signed($urandom_range(512)) - 256);
         item.b_z = COMP_W'($signed($urandom_range(512)) - 256);
      end else begin
         item.a_x = COMP_W'($urandom());
         item.a_y = COMP_W'($urandom());
         item.a_z = COMP_W'($urandom());
         item.a_w = COMP_W'($urandom());
      end
   endtask

   // Offer one transaction, with random gaps in front when idling is enabled.
   task automatic send_request(input req_payload_type item);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom()});
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_requests(input int count);
      req_payload_type item;
      repeat (count) begin
         make_random_request(item);
         send_request(item);
      end
   endtask

   // Response side: random back-pressure, plus a long hold when requested.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles_left--;
         end else if (hold_request) begin
            hold_request     = 1'b0;
            hold_cycles_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      req_payload_type directed[$];

      reset = 1'b1;
      idle_enable  = 1'b1;
      hold_request = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Zero operands, identity, full-scale corners and saturation.
      directed.push_back(make_request(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(OP_PRODUCT, 0, 0, 0, ONE, 1234, -2345, 3456, -4567));
      directed.push_back(make_request(OP_PRODUCT, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
      directed.push_back(make_request(OP_PRODUCT, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
      directed.push_back(make_request(OP_PRODUCT, 32767, -32768, 32767, -32768,
                                      -32768, 32767, -32768, 32767));
      directed.push_back(make_request(OP_PRODUCT, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
      directed.push_back(make_request(OP_PRODUCT, 321, -654, 987, -111,
                                      0, 0, 0, -ONE));
      // Rotations by non-unit quaternions, with the ignored scalar at its extremes or zero.
      directed.push_back(make_request(OP_ROTATE, -32768, -32768, -32768, -32768,
                                      32767, 32767, 32767, -32768));
      directed.push_back(make_request(OP_ROTATE, 32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, 32767));
      directed.push_back(make_request(OP_ROTATE, 0, 0, 0, 32767, -1, 1, -32768, 0));
      // Identity, quarter-turn and half-turn rotations.
      directed.push_back(make_request(OP_ROTATE, 0, 0, 0, ONE, 32767, -32768, 100, 12345));
      directed.push_back(make_request(OP_ROTATE, 0, 0, COS_45, COS_45, 1000, 2000, -3000, 0));
      directed.push_back(make_request(OP_ROTATE, COS_45, 0, 0, COS_45, -32768, 32767, 1, -1));
      directed.push_back(make_request(OP_ROTATE, ONE, 0, 0, 0, 5, 6, 7, 32767));
      directed.push_back(make_request(OP_ROTATE, 0, 0, 0, -ONE, -1, 1, -32768, -32768));
      // Exact halves: ties must round toward plus infinity.
      directed.push_back(make_request(OP_PRODUCT, 0, 0, 0, 1, 8192, 8192, 8192, 8192));
      directed.push_back(make_request(OP_PRODUCT, 0, 0, 0, -1, 8192, 8192, 8192, 8192));
      directed.push_back(make_request(OP_ROTATE, 0, 0, 0, 8192, 2, -2, 6, -1));
      directed.push_back(make_request(OP_ROTATE, 0, 0, 0, -8192, -6, 3, -3, 0));
      foreach (directed[i]) send_request(directed[i]);

      send_random_requests(RANDOM_PHASE_1);

      // Steady stream with no gaps; the long response hold fills the pipe.
      idle_enable  = 1'b0;
      hold_request = 1'b1;
      send_random_requests(STEADY_PHASE);

      idle_enable = 1'b1;
      send_random_requests(RANDOM_PHASE_2);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
